@@ hdl/tcc_pkg.sv @@
package tcc_pkg;

	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_LF  = 8'h0a;
	localparam logic [7:0] CHAR_CR  = 8'h0d;
	localparam logic [7:0] GLYPH_SPACE = 8'h20;
	localparam logic [7:0] GLYPH_NONE  = 8'h00;

	localparam logic [1:0] KIND_DRAW   = 2'd0;
	localparam logic [1:0] KIND_SCROLL = 2'd1;
	localparam logic [1:0] KIND_REPORT = 2'd2;

	localparam logic [1:0] LANG_INDENT = 2'd1;

	localparam int MAX_RESULTS = 7;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		OP_DRAW,
		OP_DRAW_ADV,
		OP_TAB,
		OP_LF,
		OP_CR
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] glyph;
		logic       indent;
	} cmd_t;

endpackage

@@ hdl/text_console_cursor.sv @@
// Channel   Handshake                    Payload
// item      item_valid / item_stall      char_code, advance, lead_byte_pending
// result    result_valid / result_stall  kind, column, row, glyph, last
// config    cfg_we (no wait)             cfg_wdata -> language_mode
//
// Front classifies each byte and queues it (two entries); the back sequencer
// emits at most one result per cycle into the output register, holding while a result is stalled.
// Each item passes the idle state, then emits its results; for carriage return, a line feed
// without scroll, and a tab fill cut short by the result limit, the main state emits no result first.
// Reset clears cursor, language_mode, queue and output valid; no clearing pass.
// A result stall holds the sequencer past its idle state; inputs keep queuing until the queue fills.
module text_console_cursor #(
	parameter int COLUMNS   = 30,
	parameter int ROWS      = 8,
	parameter int TAB_WIDTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] char_code,
	input  logic       advance,
	input  logic       lead_byte_pending,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] kind,
	output logic [4:0] column,
	output logic [2:0] row,
	output logic [7:0] glyph,
	output logic       last
);

	logic          q_full;
	logic          q_push;
	tcc_pkg::cmd_t q_cmd;
	logic          q_pop;
	logic          head_valid;
	tcc_pkg::cmd_t head_cmd;

	tcc_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.item_valid        (item_valid),
		.item_stall        (item_stall),
		.char_code         (char_code),
		.advance           (advance),
		.lead_byte_pending (lead_byte_pending),
		.q_full            (q_full),
		.q_push            (q_push),
		.q_cmd             (q_cmd)
	);

	tcc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	tcc_back #(
		.COLUMNS   (COLUMNS),
		.ROWS      (ROWS),
		.TAB_WIDTH (TAB_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_cmd     (head_cmd),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.column       (column),
		.row          (row),
		.glyph        (glyph),
		.last         (last)
	);

endmodule

@@ hdl/tcc_front.sv @@
module tcc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_wdata,
	input  logic            item_valid,
	output logic            item_stall,
	input  logic [7:0]      char_code,
	input  logic            advance,
	input  logic            lead_byte_pending,
	input  logic            q_full,
	output logic            q_push,
	output tcc_pkg::cmd_t   q_cmd
);

	logic [1:0] language_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			language_mode_q <= 2'd0;
		end else if (cfg_we) begin
			language_mode_q <= cfg_wdata;
		end
	end

	assign item_stall = q_full;
	assign q_push     = item_valid && !q_full;

	always_comb begin
		q_cmd.glyph  = char_code;
		q_cmd.indent = (language_mode_q == tcc_pkg::LANG_INDENT) && lead_byte_pending;
		case (char_code)
			tcc_pkg::CHAR_TAB: q_cmd.op = tcc_pkg::OP_TAB;
			tcc_pkg::CHAR_LF:  q_cmd.op = tcc_pkg::OP_LF;
			tcc_pkg::CHAR_CR:  q_cmd.op = tcc_pkg::OP_CR;
			default:           q_cmd.op = advance ? tcc_pkg::OP_DRAW_ADV : tcc_pkg::OP_DRAW;
		endcase
	end

endmodule

@@ hdl/tcc_queue.sv @@
module tcc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tcc_pkg::cmd_t   push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output tcc_pkg::cmd_t   head_cmd
);

	localparam int PW = (tcc_pkg::QUEUE_DEPTH > 1) ? $clog2(tcc_pkg::QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(tcc_pkg::QUEUE_DEPTH + 1);

	tcc_pkg::cmd_t   entry_q [tcc_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full       = count_q == CNTW'(tcc_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(tcc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(tcc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/tcc_back.sv @@
module tcc_back #(
	parameter int COLUMNS   = 30,
	parameter int ROWS      = 8,
	parameter int TAB_WIDTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  tcc_pkg::cmd_t   head_cmd,
	output logic            pop,
	output logic            result_valid,
	input  logic            result_stall,
	output logic [1:0]      kind,
	output logic [4:0]      column,
	output logic [2:0]      row,
	output logic [7:0]      glyph,
	output logic            last
);

	localparam int CW   = $clog2(COLUMNS);
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int MW   = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
	localparam int CXW  = (CW > 5) ? CW : 5;
	localparam int RXW  = (RW > 3) ? RW : 3;
	localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
	localparam logic [MW-1:0] LAST_MOD   = MW'(TAB_WIDTH - 1);
	localparam logic [CW-1:0] INDENT_COL = CW'(1);
	localparam logic [MW-1:0] INDENT_MOD = (TAB_WIDTH > 1) ? MW'(1) : MW'(0);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MAIN,
		S_SCROLL,
		S_REPORT
	} state_t;

	state_t          state_q;
	tcc_pkg::cmd_t   cmd_q;
	logic            tab_more_q;
	logic [2:0]      count_q;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [MW-1:0]   mod_q;
	logic            valid_q;
	logic [1:0]      kind_q;
	logic [4:0]      column_q;
	logic [2:0]      row_out_q;
	logic [7:0]      glyph_q;
	logic            last_q;

	logic            out_free;
	logic            at_right;
	logic            at_bottom;
	logic [CW-1:0]   nl_col;
	logic [MW-1:0]   nl_mod;
	logic [RW-1:0]   nl_row;
	logic [CW-1:0]   st_col;
	logic [RW-1:0]   st_row;
	logic [MW-1:0]   st_mod;
	logic            st_scroll;
	logic            tab_full;
	logic [3:0]      need;
	logic [CXW-1:0]  col_x;
	logic [RXW-1:0]  row_x;

	assign out_free  = !valid_q || !result_stall;
	assign pop       = (state_q == S_IDLE) && head_valid;
	assign at_right  = col_q == LAST_COL;
	assign at_bottom = row_q == LAST_ROW;
	assign col_x     = CXW'(col_q);
	assign row_x     = RXW'(row_q);

	always_comb begin
		nl_col = cmd_q.indent ? INDENT_COL : '0;
		nl_mod = cmd_q.indent ? INDENT_MOD : '0;
		nl_row = at_bottom ? row_q : row_q + 1'b1;
		if (at_right) begin
			st_col    = nl_col;
			st_mod    = nl_mod;
			st_row    = nl_row;
			st_scroll = at_bottom;
		end else begin
			st_col    = col_q + 1'b1;
			st_mod    = (mod_q == LAST_MOD) ? '0 : mod_q + 1'b1;
			st_row    = row_q;
			st_scroll = 1'b0;
		end
		need     = (at_right && at_bottom) ? 4'd3 : 4'd2;
		tab_full = ({1'b0, count_q} + need) > 4'(tcc_pkg::MAX_RESULTS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			valid_q    <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			mod_q      <= '0;
			count_q    <= '0;
			tab_more_q <= 1'b0;
		end else begin
			if (valid_q && !result_stall) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						cmd_q   <= head_cmd;
						count_q <= '0;
						state_q <= S_MAIN;
					end
				end
				S_MAIN: begin
					if (out_free) begin
						case (cmd_q.op)
							tcc_pkg::OP_CR: begin
								state_q <= S_REPORT;
							end
							tcc_pkg::OP_LF: begin
								col_q <= nl_col;
								mod_q <= nl_mod;
								row_q <= nl_row;
								if (at_bottom) begin
									valid_q   <= 1'b1;
									kind_q    <= tcc_pkg::KIND_SCROLL;
									column_q  <= '0;
									row_out_q <= '0;
									glyph_q   <= tcc_pkg::GLYPH_NONE;
									last_q    <= 1'b0;
								end
								state_q <= S_REPORT;
							end
							tcc_pkg::OP_TAB: begin
								if (tab_full) begin
									state_q <= S_REPORT;
								end else begin
									valid_q    <= 1'b1;
									kind_q     <= tcc_pkg::KIND_DRAW;
									column_q   <= col_x[4:0];
									row_out_q  <= row_x[2:0];
									glyph_q    <= tcc_pkg::GLYPH_SPACE;
									last_q     <= 1'b0;
									count_q    <= count_q + 1'b1;
									col_q      <= st_col;
									row_q      <= st_row;
									mod_q      <= st_mod;
									tab_more_q <= st_mod != '0;
									if (st_scroll) begin
										state_q <= S_SCROLL;
									end else if (st_mod == '0) begin
										state_q <= S_REPORT;
									end
								end
							end
							default: begin
								valid_q    <= 1'b1;
								kind_q     <= tcc_pkg::KIND_DRAW;
								column_q   <= col_x[4:0];
								row_out_q  <= row_x[2:0];
								glyph_q    <= cmd_q.glyph;
								last_q     <= 1'b0;
								tab_more_q <= 1'b0;
								if (cmd_q.op == tcc_pkg::OP_DRAW_ADV) begin
									col_q   <= st_col;
									row_q   <= st_row;
									mod_q   <= st_mod;
									state_q <= st_scroll ? S_SCROLL : S_REPORT;
								end else begin
									state_q <= S_REPORT;
								end
							end
						endcase
					end
				end
				S_SCROLL: begin
					if (out_free) begin
						valid_q   <= 1'b1;
						kind_q    <= tcc_pkg::KIND_SCROLL;
						column_q  <= '0;
						row_out_q <= '0;
						glyph_q   <= tcc_pkg::GLYPH_NONE;
						last_q    <= 1'b0;
						count_q   <= count_q + 1'b1;
						state_q   <= tab_more_q ? S_MAIN : S_REPORT;
					end
				end
				S_REPORT: begin
					if (out_free) begin
						valid_q   <= 1'b1;
						kind_q    <= tcc_pkg::KIND_REPORT;
						column_q  <= col_x[4:0];
						row_out_q <= row_x[2:0];
						glyph_q   <= tcc_pkg::GLYPH_NONE;
						last_q    <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = valid_q;
	assign kind         = kind_q;
	assign column       = column_q;
	assign row          = row_out_q;
	assign glyph        = glyph_q;
	assign last         = last_q;

endmodule

@@ sim/testbench.sv @@
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLUMNS   = 30;
	localparam int ROWS      = 8;
	localparam int TAB_WIDTH = 4;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 200;

	typedef struct {
		logic [1:0] kind;
		logic [4:0] column;
		logic [2:0] row;
		logic [7:0] glyph;
		logic       last;
	} cell_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_wdata = '0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	logic [7:0] char_code = '0;
	logic       advance = 1'b0;
	logic       lead_byte_pending = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [1:0] kind;
	logic [4:0] column;
	logic [2:0] row;
	logic [7:0] glyph;
	logic       last;

	cell_result_t cursor_results_due[$];
	int           cursor_col = 0;
	int           cursor_row = 0;
	logic [1:0]   language_mode = '0;
	int           errors = 0;
	int           sender_idle_pct = 0;
	int           receiver_idle_pct = 0;
	bit           hold_req = 1'b0;
	int           hold_left = 0;

	text_console_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.TAB_WIDTH(TAB_WIDTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.char_code(char_code),
		.advance(advance),
		.lead_byte_pending(lead_byte_pending),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind(kind),
		.column(column),
		.row(row),
		.glyph(glyph),
		.last(last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("text_console_cursor verification failed");
		$finish;
	end

	function automatic void push_result(logic [1:0] k, int col, int r, logic [7:0] g,
			logic l);
		cell_result_t res;
		res.kind = k;
		res.column = col[4:0];
		res.row = r[2:0];
		res.glyph = g;
		res.last = l;
		cursor_results_due.push_back(res);
	endfunction

	function automatic int start_line(bit indent);
		int added;
		added = 0;
		if (cursor_row + 1 < ROWS) begin
			cursor_row++;
		end else begin
			push_result(tcc_pkg::KIND_SCROLL, 0, 0, tcc_pkg::GLYPH_NONE, 1'b0);
			added = 1;
		end
		cursor_col = indent ? 1 : 0;
		return added;
	endfunction

	function automatic void advance_cursor(logic [7:0] c, logic adv, logic lead);
		bit indent;
		bit done;
		int n;
		int need;
		indent = (language_mode == tcc_pkg::LANG_INDENT) && lead;
		n = 0;
		if (c == tcc_pkg::CHAR_TAB) begin
			done = 1'b0;
			while (!done) begin
				need = (cursor_col + 1 >= COLUMNS && cursor_row + 1 >= ROWS) ? 3 : 2;
				if (n + need > tcc_pkg::MAX_RESULTS) begin
					done = 1'b1;
				end else begin
					push_result(tcc_pkg::KIND_DRAW, cursor_col, cursor_row,
						tcc_pkg::GLYPH_SPACE, 1'b0);
					n++;
					cursor_col++;
					if (cursor_col >= COLUMNS)
						n += start_line(indent);
					if (cursor_col % TAB_WIDTH == 0)
						done = 1'b1;
				end
			end
		end else if (c == tcc_pkg::CHAR_LF) begin
			n += start_line(indent);
		end else if (c != tcc_pkg::CHAR_CR) begin
			push_result(tcc_pkg::KIND_DRAW, cursor_col, cursor_row, c, 1'b0);
			if (adv) begin
				cursor_col++;
				if (cursor_col >= COLUMNS)
					n += start_line(indent);
			end
		end
		push_result(tcc_pkg::KIND_REPORT, cursor_col, cursor_row, tcc_pkg::GLYPH_NONE, 1'b1);
	endfunction

	// result side: check each transfer, then pick the next stall
	always @(posedge clk) begin
		cell_result_t exp_res;
		if (arst_n && result_valid && !result_stall) begin
			if (cursor_results_due.size() == 0) begin
				$error("result transfer with nothing due: kind %0d column %0d row %0d",
					kind, column, row);
				errors++;
			end else begin
				exp_res = cursor_results_due.pop_front();
				if (kind !== exp_res.kind) begin
					$error("kind: expected %0d, got %0d", exp_res.kind, kind);
					errors++;
				end
				if (column !== exp_res.column) begin
					$error("column: expected %0d, got %0d", exp_res.column, column);
					errors++;
				end
				if (row !== exp_res.row) begin
					$error("row: expected %0d, got %0d", exp_res.row, row);
					errors++;
				end
				if (glyph !== exp_res.glyph) begin
					$error("glyph: expected %0d, got %0d", exp_res.glyph, glyph);
					errors++;
				end
				if (last !== exp_res.last) begin
					$error("last: expected %0d, got %0d", exp_res.last, last);
					errors++;
				end
			end
		end
		result_stall <= (hold_left != 0) || ($urandom_range(0, 99) < receiver_idle_pct);
	end

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req <= 1'b0;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	task automatic send_char(logic [7:0] c, logic adv, logic lead);
		int gap;
		gap = 0;
		while (gap < 200 && $urandom_range(0, 99) < sender_idle_pct)
			gap++;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		char_code <= c;
		advance <= adv;
		lead_byte_pending <= lead;
		do @(posedge clk); while (item_stall);
		advance_cursor(c, adv, lead);
	endtask

	task automatic send_random_char();
		int pick;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 14)
			c = tcc_pkg::CHAR_TAB;
		else if (pick < 24)
			c = tcc_pkg::CHAR_LF;
		else if (pick < 28)
			c = tcc_pkg::CHAR_CR;
		else
			c = 8'($urandom_range(0, 255));
		send_char(c, $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)));
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (cursor_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_language_mode(logic [1:0] mode);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		language_mode = mode;
	endtask

	task automatic set_idling(int sender_pct, int receiver_pct);
		sender_idle_pct = sender_pct;
		receiver_idle_pct <= receiver_pct;
	endtask

	// plain drawing, advance off, carriage return, short tab, unindented line feed
	task automatic basic_drawing_test();
		write_language_mode(2'd0);
		send_char("A", 1'b0, 1'b0);
		send_char(8'hff, 1'b1, 1'b1);
		send_char(8'h00, 1'b1, 1'b0);
		send_char(tcc_pkg::CHAR_CR, 1'b1, 1'b1);
		send_char(tcc_pkg::CHAR_TAB, 1'b0, 1'b0);
		send_char(tcc_pkg::CHAR_LF, 1'b1, 1'b1);
		wait_idle();
	endtask

	// walk to the row above the bottom, then tab across the right edge onto an indented bottom line
	task automatic indent_tab_wrap_test();
		write_language_mode(tcc_pkg::LANG_INDENT);
		send_char(tcc_pkg::CHAR_LF, 1'b0, 1'b1);
		repeat (5) send_char(tcc_pkg::CHAR_LF, 1'b1, 1'b0);
		repeat (7) send_char(tcc_pkg::CHAR_TAB, 1'b1, 1'b0);
		send_char(tcc_pkg::CHAR_TAB, 1'b0, 1'b1);
		send_char("z", 1'b1, 1'b1);
		wait_idle();
	endtask

	task automatic random_traffic_test(int count, logic [1:0] mode_a, logic [1:0] mode_b);
		write_language_mode(mode_a);
		repeat (count / 2) send_random_char();
		write_language_mode(mode_b);
		repeat (count - count / 2) send_random_char();
		wait_idle();
	endtask

	// receiver holds off while the sender keeps offering
	task automatic receiver_backpressure_test();
		write_language_mode(tcc_pkg::LANG_INDENT);
		hold_req <= 1'b1;
		repeat (14) send_random_char();
		wait_idle();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(37, 80);
		basic_drawing_test();
		indent_tab_wrap_test();
		random_traffic_test(62, 2'd3, 2'd1);
		set_idling(80, 37);
		random_traffic_test(62, 2'd2, 2'd0);
		set_idling(0, 0);
		receiver_backpressure_test();
		random_traffic_test(62, 2'd1, 2'd3);
		wait_idle();
		if (errors == 0)
			$display("text_console_cursor verification clean");
		else
			$display("text_console_cursor verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/tcc_pkg.sv
hdl/tcc_front.sv
hdl/tcc_queue.sv
hdl/tcc_back.sv
hdl/text_console_cursor.sv
sim/testbench.sv
